@@ hdl/afd_pkg.sv @@
package afd_pkg;

    localparam int unsigned HDR_SIZE       = 8;
    localparam int unsigned FRAME_OVERHEAD = 10;
    localparam int unsigned COUNT_W        = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int unsigned CRC_TOP  = 15;
    localparam int unsigned PADDR_W  = 3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_CRC      = 3'd5
    } frame_status_t;

    typedef enum logic {
        REG_MAGIC       = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic          is_status;
        logic [7:0]    payload_byte;
        frame_status_t status;
        logic [7:0]    type_flags;
        logic [15:0]   source_id;
        logic [15:0]   dest_id;
        logic [7:0]    sequence_res;
        logic [7:0]    payload_length;
    } out_word_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[CRC_TOP]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/app_frame_decoder_crc_check.sv @@
// Channel   Ports                          Payload
// input     s_valid s_ready s_word         in_word_t  (rx_byte, end_of_frame)
// result    m_valid m_ready m_word         out_word_t (is_status .. payload_length)
// config    psel penable pwrite paddr ...  magic_byte @0x0, max_payload @0x4
// One word per cycle while s_ready is high; each result is registered on accept.
// The whole byte step (CRC update over one byte, header capture, status) sits
// between the accept edge and the result register.
// A two-entry output (result register plus skid) lets input flow while m_ready is low;
// s_ready drops only when both entries are full.
// Synchronous active-low reset clears frame state and sets magic 0, max_payload 255.
module app_frame_decoder_crc_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  afd_pkg::in_word_t              s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output afd_pkg::out_word_t             m_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [afd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import afd_pkg::*;

    logic [7:0]         magic_reg;
    logic [7:0]         max_payload_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        crc_reg, crc_next;
    logic               magic_ok_reg, magic_ok_next;
    logic [7:0]         type_reg, type_next;
    logic [15:0]        source_reg, source_next;
    logic [15:0]        dest_reg, dest_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         len_reg, len_next;
    logic [15:0]        tail_reg, tail_next;

    logic               out_valid_reg;
    out_word_t          out_reg;
    logic               skid_valid_reg;
    out_word_t          skid_reg;

    logic               s_accept;
    logic               res_valid;
    out_word_t          res;
    logic [COUNT_W-1:0] count_sat;
    logic [15:0]        crc_step;
    logic [COUNT_W-1:0] payload_end;
    logic [COUNT_W-1:0] frame_len;
    frame_status_t      st;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg       <= 8'd0;
            max_payload_reg <= 8'hFF;
        end else if (cfg_write) begin
            unique case (reg_index_t'(paddr[2]))
                REG_MAGIC:       magic_reg       <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index_t'(paddr[2]))
            REG_MAGIC:       prdata = {24'd0, magic_reg};
            REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        magic_ok_next = magic_ok_reg;
        type_next     = type_reg;
        source_next   = source_reg;
        dest_next     = dest_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        unique case (count_reg)
            9'd0:    magic_ok_next     = (s_word.rx_byte == magic_reg);
            9'd1:    type_next         = s_word.rx_byte;
            9'd2:    source_next[15:8] = s_word.rx_byte;
            9'd3:    source_next[7:0]  = s_word.rx_byte;
            9'd4:    dest_next[15:8]   = s_word.rx_byte;
            9'd5:    dest_next[7:0]    = s_word.rx_byte;
            9'd6:    seq_next          = s_word.rx_byte;
            9'd7:    len_next          = s_word.rx_byte;
            default: ;
        endcase

        crc_step  = (count_reg >= COUNT_W'(2)) ? crc_byte(crc_reg, tail_reg[15:8]) : crc_reg;
        tail_next = {tail_reg[7:0], s_word.rx_byte};
        count_sat = (count_reg < COUNT_MAX) ? count_reg + COUNT_W'(1) : count_reg;

        payload_end = COUNT_W'(HDR_SIZE) + {1'b0, len_reg};
        frame_len   = COUNT_W'(FRAME_OVERHEAD) + {1'b0, len_next};

        if (count_sat < COUNT_W'(FRAME_OVERHEAD)) begin
            st = ST_SHORT;
        end else if (!magic_ok_next) begin
            st = ST_MAGIC;
        end else if (len_next > max_payload_reg) begin
            st = ST_TOO_LONG;
        end else if (count_sat != frame_len) begin
            st = ST_MISMATCH;
        end else if (crc_step != tail_next) begin
            st = ST_CRC;
        end else begin
            st = ST_OK;
        end

        res        = '0;
        res.status = ST_OK;
        if (s_word.end_of_frame) begin
            res_valid     = 1'b1;
            res.is_status = 1'b1;
            res.status    = st;
            if (st == ST_OK) begin
                res.type_flags     = type_next;
                res.source_id      = source_next;
                res.dest_id        = dest_next;
                res.sequence_res   = seq_next;
                res.payload_length = len_next;
            end
            count_next = '0;
            crc_next   = CRC_INIT;
        end else begin
            res_valid        = (count_reg >= COUNT_W'(HDR_SIZE)) && (count_reg < payload_end);
            res.payload_byte = s_word.rx_byte;
            count_next       = count_sat;
            crc_next         = crc_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else if (s_accept) begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_ok_reg <= 1'b0;
            type_reg     <= '0;
            source_reg   <= '0;
            dest_reg     <= '0;
            seq_reg      <= '0;
            len_reg      <= '0;
            tail_reg     <= '0;
        end else if (s_accept) begin
            magic_ok_reg <= magic_ok_next;
            type_reg     <= type_next;
            source_reg   <= source_next;
            dest_reg     <= dest_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            tail_reg     <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_accept && res_valid;
                end
            end else if (s_accept && res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept && res_valid) begin
                out_reg <= res;
            end
        end else if (s_accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> !skid_valid_reg)
        else $error("skid entry not moved after the output was taken");

    a_payload_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word.is_status) |-> (m_word.status == ST_OK && m_word.dest_id == 16'd0))
        else $error("payload result carries status or header data");

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_word.end_of_frame) |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after the last byte");

    a_bad_status_no_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.is_status && m_word.status != ST_OK) |->
            (m_word.source_id == 16'd0 && m_word.payload_length == 8'd0))
        else $error("failed status carries header fields");

endmodule
